// ===== src/mkrd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkrd_pkg
// Shared types and constants of the multi-key release debouncer.
// ----------------------------------------------------------------------------
package mkrd_pkg;

  localparam int KeyW            = 4;
  localparam int KeyCountDefault = 4;
  localparam int CountW          = 8;
  localparam int ApbAddrW        = 3;
  localparam int ApbDataW        = 32;
  localparam int InDataW         = 16;
  localparam int OutDataW        = 8;

  localparam logic [CountW-1:0] HoldTimeReset = CountW'(10);

  // register index within the configuration space
  typedef enum logic [0:0] {
    RegHoldTime = 1'b0
  } reg_idx_e;

  // per-key outcome of one scan tick
  typedef struct packed {
    logic arm;
    logic fire;
  } key_flags_t;

  // one scan tick as held in the input register
  typedef struct packed {
    logic [KeyW-1:0] event_replace;
    logic            event_take;
    logic            now_clear;
    logic [KeyW-1:0] pressed;
  } scan_item_t;

endpackage

// ===== src/mkrd_apb_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkrd_apb_regs
// Configuration register file behind the APB port (hold time).
// ----------------------------------------------------------------------------
module mkrd_apb_regs
  import mkrd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output logic [CountW-1:0]   hold_time_o
);

  logic [CountW-1:0] hold_time_q;
  logic [CountW-1:0] hold_time_d;
  reg_idx_e          reg_idx;
  logic              addr_hit;
  logic              wr_en;

  assign reg_idx  = reg_idx_e'(paddr[ApbAddrW-1]);
  assign addr_hit = (reg_idx == RegHoldTime);
  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite && pready;

  always_comb begin
    hold_time_d = hold_time_q;
    if (wr_en && addr_hit) begin
      hold_time_d = pwdata[CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_time_q <= HoldTimeReset;
    end else begin
      hold_time_q <= hold_time_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (addr_hit) begin
      prdata = {{(ApbDataW-CountW){1'b0}}, hold_time_q};
    end
  end

  assign hold_time_o = hold_time_q;

endmodule

// ===== src/mkrd_key_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkrd_key_cell
// Per-key edge tracking and press / release tick counter.
// ----------------------------------------------------------------------------
module mkrd_key_cell
  import mkrd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              pressed_i,
  input  logic [CountW-1:0] hold_time_i,
  output key_flags_t        flags_o
);

  logic              prev_q, prev_d;
  logic              rise_q, rise_d;
  logic              fall_q, fall_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              level_chg;
  logic [CountW-1:0] cnt_inc;
  logic [CountW-1:0] cnt_dec;

  assign level_chg = pressed_i ^ prev_q;
  assign cnt_inc   = cnt_q + CountW'(1);
  assign cnt_dec   = cnt_q - CountW'(1);

  always_comb begin
    prev_d  = pressed_i;
    rise_d  = level_chg ? pressed_i : rise_q;
    fall_d  = level_chg ? !pressed_i : fall_q;
    cnt_d   = cnt_q;
    flags_o = '0;
    if (pressed_i) begin
      if (rise_d) begin
        cnt_d = cnt_inc;
        // count >= hold_time - 1
        if (({1'b0, cnt_inc} + (CountW+1)'(1)) >= {1'b0, hold_time_i}) begin
          rise_d       = 1'b0;
          cnt_d        = hold_time_i;
          flags_o.arm  = 1'b1;
        end
      end
    end else begin
      if (fall_d) begin
        cnt_d = cnt_dec;
        if (cnt_dec <= CountW'(1)) begin
          fall_d       = 1'b0;
          cnt_d        = '0;
          flags_o.fire = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= 1'b0;
      rise_q <= 1'b0;
      fall_q <= 1'b0;
      cnt_q  <= '0;
    end else if (en_i) begin
      prev_q <= prev_d;
      rise_q <= rise_d;
      fall_q <= fall_d;
      cnt_q  <= cnt_d;
    end
  end

  a_pending_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rise_q && fall_q))
    else $error("press and release count both pending");

endmodule

// ===== src/mkrd_fire_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkrd_fire_merge
// Armed set, fired key set and event register; merges per-key flags in
// index order.
// ----------------------------------------------------------------------------
module mkrd_fire_merge
  import mkrd_pkg::*;
#(
  parameter int KEY_COUNT = KeyCountDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  key_flags_t      flags_i [KeyW],
  input  logic            now_clear_i,
  input  logic            event_take_i,
  input  logic [KeyW-1:0] event_replace_i,
  output logic [KeyW-1:0] key_now_o,
  output logic [KeyW-1:0] key_event_o
);

  localparam int              NKeys   = (KEY_COUNT < KeyW) ? KEY_COUNT : KeyW;
  localparam logic [KeyW-1:0] KeyMask = KeyW'((1 << NKeys) - 1);

  logic [KeyW-1:0] armed_q, armed_d;
  logic [KeyW-1:0] cur_q, cur_d;
  logic [KeyW-1:0] evt_q, evt_d;
  logic [KeyW-1:0] scan_cur;
  logic [KeyW-1:0] scan_evt;

  always_comb begin
    armed_d  = armed_q;
    scan_cur = cur_q;
    scan_evt = evt_q;
    for (int i = 0; i < KeyW; i++) begin
      if (flags_i[i].arm) begin
        armed_d[i] = 1'b1;
      end
      if (flags_i[i].fire) begin
        if (armed_d != '0) begin
          scan_cur = armed_d;
          scan_evt = armed_d;
        end
        armed_d = '0;
      end
    end
    cur_d = now_clear_i  ? '0 : scan_cur;
    evt_d = event_take_i ? event_replace_i : scan_evt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= '0;
      cur_q   <= '0;
      evt_q   <= '0;
    end else if (en_i) begin
      armed_q <= armed_d;
      cur_q   <= cur_d;
      evt_q   <= evt_d;
    end
  end

  assign key_now_o   = scan_cur;
  assign key_event_o = scan_evt;

  a_armed_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (armed_q & ~KeyMask) == '0)
    else $error("armed mark on a key beyond the key count");

endmodule

// ===== src/multi_key_release_debouncer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_key_release_debouncer_top
// Counter-based key debouncer that reports the armed key set on release.
//
// channel   | direction | payload
// s_axis    | in        | tdata: pressed, now_clear, event_take, event_replace
// m_axis    | out       | tdata: key_now, key_event
// apb       | in/out    | hold_time at byte address 0
//
// one scan tick per cycle while m_axis is not stalled; a tick passes through the
// input register, then scan and merge into the result register
// reset clears all key state and loads hold_time with 10
// a stall on m_axis holds the result; s_axis keeps taking ticks while the
// input register can move on
// ----------------------------------------------------------------------------
module multi_key_release_debouncer_top
  import mkrd_pkg::*;
#(
  parameter int KEY_COUNT = KeyCountDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // [3:0] pressed, [4] now_clear, [5] event_take, [9:6] event_replace
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [3:0] key_now, [7:4] key_event
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int NKeys = (KEY_COUNT < KeyW) ? KEY_COUNT : KeyW;

  logic                in_valid_q;
  scan_item_t          in_item_q;
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic                advance;
  logic                in_acc;
  logic [CountW-1:0]   hold_time;
  key_flags_t          flags [KeyW];
  logic [KeyW-1:0]     key_now;
  logic [KeyW-1:0]     key_event;

  mkrd_apb_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .hold_time_o (hold_time)
  );

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_item_q <= scan_item_t'(s_axis_tdata[$bits(scan_item_t)-1:0]);
    end
  end

  for (genvar k = 0; k < KeyW; k++) begin : g_key
    if (k < NKeys) begin : g_cell
      mkrd_key_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .en_i        (advance),
        .pressed_i   (in_item_q.pressed[k]),
        .hold_time_i (hold_time),
        .flags_o     (flags[k])
      );
    end else begin : g_none
      assign flags[k] = '0;
    end
  end

  mkrd_fire_merge #(
    .KEY_COUNT (KEY_COUNT)
  ) u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (advance),
    .flags_i         (flags),
    .now_clear_i     (in_item_q.now_clear),
    .event_take_i    (in_item_q.event_take),
    .event_replace_i (in_item_q.event_replace),
    .key_now_o       (key_now),
    .key_event_o     (key_event)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {key_event, key_now};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |-> !s_axis_tready)
    else $error("input register overwritten while held");

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("scanned tick lost before the result register");

  a_held_item_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(in_valid_q) && !$past(advance)) |-> $stable(in_item_q))
    else $error("held scan tick changed");

endmodule
